// ----- rtl/csm_pkg.sv -----
// Shared types and constants for the charger status monitor.
// No dependencies; every other file in rtl depends on this package.
`timescale 1ns / 1ps

package csm_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TIMEOUT_TICKS   = 3'd0;
   localparam logic [2:0] CSR_PAUSE_TICKS     = 3'd1;
   localparam logic [2:0] CSR_SETTLE_TICKS    = 3'd2;
   localparam logic [2:0] CSR_FAULT_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_DUTY_CHARGING   = 3'd4;
   localparam logic [2:0] CSR_DUTY_STANDARD   = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Register reset values.
   localparam logic [23:0] TIMEOUT_RESET   = 24'd14400;
   localparam logic [15:0] PAUSE_RESET     = 16'd120;
   localparam logic [7:0]  SETTLE_RESET    = 8'd2;
   localparam logic [5:0]  THRESHOLD_RESET = 6'd2;
   localparam logic [6:0]  DUTY_CHG_RESET  = 7'd100;
   localparam logic [6:0]  DUTY_STD_RESET  = 7'd15;

   localparam logic [6:0]  DUTY_MAX = 7'd100;

   // Port kinds.
   localparam logic [1:0] USB_NONE     = 2'd0;
   localparam logic [1:0] USB_STANDARD = 2'd1;

   // Status codes.
   localparam logic [1:0] STATUS_DISCHARGING = 2'd0;
   localparam logic [1:0] STATUS_CHARGING    = 2'd1;
   localparam logic [1:0] STATUS_COMPLETE    = 2'd2;
   localparam logic [1:0] STATUS_FAULT       = 2'd3;

   // Transition counts fit six bits for any ring of up to 32 entries.
   localparam int TRANS_W = 6;
   localparam int TICKS_W = 25;

   typedef struct packed {
      logic en;
      logic sample;
   } ring_wr_type;

   typedef struct packed {
      logic [1:0] status;
      logic       charger_on;
      logic [6:0] limit_duty;
      logic       pausing;
   } rsp_type;

   function automatic logic [6:0] sat_duty(input logic [6:0] d);
      return (d > DUTY_MAX) ? DUTY_MAX : d;
   endfunction

endpackage

// ----- rtl/csm_interfaces.sv -----
// Valid/ready channel interfaces for sample beats, result beats and
// register writes. Depends on csm_pkg for widths.
`timescale 1ns / 1ps

interface csm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] usb_kind;
   logic       charge_signal;
   modport source (output valid, output usb_kind, output charge_signal, input ready);
   modport sink   (input valid, input usb_kind, input charge_signal, output ready);
endinterface

interface csm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       charger_on;
   logic [6:0] limit_duty;
   logic       pausing;
   modport source (output valid, output status, output charger_on, output limit_duty,
                   output pausing, input ready);
   modport sink   (input valid, input status, input charger_on, input limit_duty,
                   input pausing, output ready);
endinterface

interface csm_csr_if;
   logic                         valid;
   logic                         ready;
   logic [csm_pkg::CSR_INDEX_W-1:0] index;
   logic [csm_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/csm_ring.sv -----
// Sample ring with write pointer and transition counter.
// Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_ring #(
   parameter int RING_DEPTH = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  csm_pkg::ring_wr_type         wr,
   output logic [csm_pkg::TRANS_W-1:0]  trans_count
);
   import csm_pkg::*;

   localparam int POS_W = $clog2(RING_DEPTH);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(RING_DEPTH - 1);

   logic [RING_DEPTH-1:0] ring_ff, ring_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [RING_DEPTH-1:0] diff;

   // The count covers the ring as it stands after this beat's write,
   // including the wrap from the last entry to the first.
   always_comb begin
      ring_in = ring_ff;
      ring_in[pos_ff] = wr.sample;
      for (int i = 0; i < RING_DEPTH; i++) begin
         diff[i] = ring_in[i] ^ ring_in[(i + RING_DEPTH - 1) % RING_DEPTH];
      end
      trans_count = '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         trans_count = trans_count + TRANS_W'(diff[i]);
      end
      pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= '0;
         pos_ff  <= '0;
      end else if (wr.en) begin
         ring_ff <= ring_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

// ----- rtl/csm_out_stage.sv -----
// Result register between the decision logic and the result channel.
// Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  csm_pkg::rsp_type load_data,
   output logic             can_load,
   output logic             out_valid,
   input  logic             out_ready,
   output csm_pkg::rsp_type out_data
);
   import csm_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   // A new beat may enter whenever the held one is empty or leaves now.
   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// ----- rtl/charger_status_monitor_core.sv -----
// Top level of the charger status monitor: register file, tick counters,
// status decision. Depends on csm_pkg, csm_interfaces, csm_ring, csm_out_stage.
`timescale 1ns / 1ps

// Usage:
// Each sample beat on req_port carries the USB port kind and the charge
// indicator level. For every accepted sample beat exactly one result beat
// appears on rsp_port with the status, the charger enable, the current-limit
// duty and the pause flag.
// Registers are written through csr_port, which is always ready; index i
// selects the i-th register (timeout, pause, settle, fault threshold, duty for
// charging ports, duty for standard ports). Other indexes are ignored. Writes
// are meant to happen only while no sample beat is in flight.
// A sample's result is registered at the accepting edge and shown in the next
// cycle. Throughput is one sample beat per cycle while rsp_port is ready, set
// by the single result register; all tick state updates at the accepting edge.
// When the receiver stalls, the result register holds its beat, and req_port
// stays ready only if that beat leaves in the same cycle, so one result
// at most waits.
// Synchronous reset restores the register defaults, clears the sample ring,
// counters and the pause, and empties the result register.
module charger_status_monitor_core #(
   parameter int RING_DEPTH = 7
) (
   input logic      clock,
   input logic      reset,
   csm_req_if.sink  req_port,
   csm_rsp_if.source rsp_port,
   csm_csr_if.sink  csr_port
);
   import csm_pkg::*;

   // Configuration registers.
   logic [23:0] timeout_ff;
   logic [15:0] pause_cfg_ff;
   logic [7:0]  settle_ff;
   logic [5:0]  threshold_ff;
   logic [6:0]  duty_chg_ff;
   logic [6:0]  duty_std_ff;

   // Tick state.
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [15:0]        pause_left_ff, pause_left_in;

   logic        accept;
   logic        can_load;
   ring_wr_type ring_wr;
   logic [TRANS_W-1:0] trans_count;
   rsp_type     result;
   rsp_type     rsp_data;
   logic        enabled;
   logic [TICKS_W-1:0] ticks_inc;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         pause_cfg_ff <= PAUSE_RESET;
         settle_ff    <= SETTLE_RESET;
         threshold_ff <= THRESHOLD_RESET;
         duty_chg_ff  <= DUTY_CHG_RESET;
         duty_std_ff  <= DUTY_STD_RESET;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_TIMEOUT_TICKS:   timeout_ff   <= csr_port.data[23:0];
            CSR_PAUSE_TICKS:     pause_cfg_ff <= csr_port.data[15:0];
            CSR_SETTLE_TICKS:    settle_ff    <= csr_port.data[7:0];
            CSR_FAULT_THRESHOLD: threshold_ff <= csr_port.data[5:0];
            CSR_DUTY_CHARGING:   duty_chg_ff  <= csr_port.data[6:0];
            CSR_DUTY_STANDARD:   duty_std_ff  <= csr_port.data[6:0];
            default: ;
         endcase
      end
   end

   assign req_port.ready = can_load;
   assign accept = req_port.valid && can_load;

   // The ring is written only on beats outside a pause.
   assign ring_wr.en     = accept && (pause_left_ff == '0);
   assign ring_wr.sample = req_port.charge_signal;

   csm_ring #(
      .RING_DEPTH(RING_DEPTH)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .wr          (ring_wr),
      .trans_count (trans_count)
   );

   always_comb begin
      result        = '0;
      ticks_in      = ticks_ff;
      pause_left_in = pause_left_ff;
      enabled       = (req_port.usb_kind != USB_NONE);
      // The counter saturates rather than wrapping.
      ticks_inc     = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;

      if (pause_left_ff != '0) begin
         // During a pause the beat only counts the pause down and flags pausing.
         pause_left_in  = pause_left_ff - 1'b1;
         result.pausing = 1'b1;
      end else begin
         result.charger_on = enabled;
         if (req_port.usb_kind == USB_STANDARD) begin
            result.limit_duty = sat_duty(duty_std_ff);
         end else if (enabled) begin
            result.limit_duty = sat_duty(duty_chg_ff);
         end

         if (enabled) begin
            ticks_in = ticks_inc;
            if (trans_count > threshold_ff) begin
               result.status = STATUS_FAULT;
            end else if (req_port.charge_signal) begin
               result.status = STATUS_CHARGING;
            end else if (ticks_inc > TICKS_W'(settle_ff)) begin
               result.status = STATUS_COMPLETE;
            end else begin
               result.status = STATUS_DISCHARGING;
            end
         end else begin
            ticks_in = '0;
         end

         // Timeout: switch off and start the pause.
         if (ticks_in > TICKS_W'(timeout_ff)) begin
            result.status     = STATUS_DISCHARGING;
            result.charger_on = 1'b0;
            result.limit_duty = '0;
            result.pausing    = (pause_cfg_ff != '0);
            ticks_in          = '0;
            pause_left_in     = pause_cfg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff      <= '0;
         pause_left_ff <= '0;
      end else if (accept) begin
         ticks_ff      <= ticks_in;
         pause_left_ff <= pause_left_in;
      end
   end

   csm_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (result),
      .can_load  (can_load),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_data  (rsp_data)
   );

   assign rsp_port.status     = rsp_data.status;
   assign rsp_port.charger_on = rsp_data.charger_on;
   assign rsp_port.limit_duty = rsp_data.limit_duty;
   assign rsp_port.pausing    = rsp_data.pausing;

endmodule

// ----- rtl/csm_checker.sv -----
// Port-level checks for the charger status monitor and the bind that
// attaches them to charger_status_monitor_core. Depends on csm_pkg for status codes.
`timescale 1ns / 1ps

module csm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_charger_on,
   input logic [6:0] rsp_limit_duty,
   input logic       rsp_pausing
);
   import csm_pkg::*;

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_charger_on) && $stable(rsp_limit_duty) && $stable(rsp_pausing))
      else $error("result beat changed while stalled");

   // Every accepted sample yields a result on the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted sample");

   // Only an enabled charger reports a nonzero status or duty.
   a_off_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_charger_on |-> rsp_status == STATUS_DISCHARGING
         && rsp_limit_duty == 7'd0)
      else $error("status or duty reported with charger off");

   // A pausing result has the charger off.
   a_pause_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pausing |-> !rsp_charger_on)
      else $error("charger on during pause");

   // Reset leaves the result register empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind charger_status_monitor_core csm_checker u_csm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_status     (rsp_port.status),
   .rsp_charger_on (rsp_port.charger_on),
   .rsp_limit_duty (rsp_port.limit_duty),
   .rsp_pausing    (rsp_port.pausing)
);
